// ===== hw/rtl/gamepad_report_key_queue_unit_macros.svh =====
// ---------------------------------------------------------------------------
// gamepad report key queue assertion macros
// concurrent checks shared by the key queue rtl
// ---------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_KEY_QUEUE_UNIT_MACROS_SVH
`define GAMEPAD_REPORT_KEY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is held
`define GPRKQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key queue check failed");

// next-cycle implication, masked while reset is held
`define GPRKQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key queue check failed");

`endif

// ===== hw/rtl/gprkq_pkg.sv =====
// ---------------------------------------------------------------------------
// gamepad report key queue package
// key codes, input kinds, register indexes and the push request bundle
// ---------------------------------------------------------------------------
package gprkq_pkg;

  // key codes as delivered on the result channel
  typedef enum logic [3:0] {
    KEY_NONE  = 4'd0,
    KEY_UP    = 4'd1,
    KEY_DOWN  = 4'd2,
    KEY_LEFT  = 4'd3,
    KEY_RIGHT = 4'd4,
    KEY_ENTER = 4'd5,
    KEY_ESC   = 4'd6,
    KEY_EDIT  = 4'd7,
    KEY_CMD   = 4'd8,
    KEY_PGUP  = 4'd9,
    KEY_PGDN  = 4'd10
  } key_code_t;

  // what an input beat carries
  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    CFG_AXIS_MID    = 1'b0,
    CFG_AXIS_MARGIN = 1'b1
  } cfg_index_t;

  localparam int AXIS_W = 8;
  localparam int BTN_W  = 8;
  localparam int LEFT_W = 6;

  localparam logic [AXIS_W-1:0] AXIS_MID_RST    = 8'h7F;
  localparam logic [AXIS_W-1:0] AXIS_MARGIN_RST = 8'h40;
  localparam logic [BTN_W-1:0]  BUTTONS_RST     = 8'h00;

  // button bit positions
  localparam int BTN_X      = 0;
  localparam int BTN_A      = 1;
  localparam int BTN_B      = 2;
  localparam int BTN_Y      = 3;
  localparam int BTN_L      = 4;
  localparam int BTN_R      = 5;
  localparam int BTN_SELECT = 6;
  localparam int BTN_START  = 7;

  // press sources, in queueing order
  localparam int NUM_PUSH = 11;
  localparam int RANK_W   = 4;

  localparam key_code_t PUSH_CODE [NUM_PUSH] = '{
    KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_ENTER, KEY_ENTER,
    KEY_ESC, KEY_EDIT, KEY_CMD, KEY_PGUP, KEY_PGDN
  };

  // press edges of one report, each with its place among the pushed codes
  typedef struct packed {
    logic [NUM_PUSH-1:0]             hit;
    logic [NUM_PUSH-1:0][RANK_W-1:0] rank;
    logic [RANK_W-1:0]               total;
  } push_req_t;

endpackage

// ===== hw/rtl/gprkq_edge.sv =====
// ---------------------------------------------------------------------------
// gamepad report press edge detector
// holds the previous report and finds the press edges of a new one
// ---------------------------------------------------------------------------
module gprkq_edge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         report_en,
  input  logic [gprkq_pkg::AXIS_W-1:0] axis_x,
  input  logic [gprkq_pkg::AXIS_W-1:0] axis_y,
  input  logic [gprkq_pkg::BTN_W-1:0]  buttons,
  input  logic [gprkq_pkg::AXIS_W-1:0] axis_mid,
  input  logic [gprkq_pkg::AXIS_W-1:0] axis_margin,
  output gprkq_pkg::push_req_t         push_req
);

  localparam int THR_W = gprkq_pkg::AXIS_W + 2;

  logic [gprkq_pkg::AXIS_W-1:0] last_x_r, last_x_nxt;
  logic [gprkq_pkg::AXIS_W-1:0] last_y_r, last_y_nxt;
  logic [gprkq_pkg::BTN_W-1:0]  last_btn_r, last_btn_nxt;

  logic signed [THR_W-1:0] thr_lo;
  logic        [THR_W-1:0] thr_hi;
  logic                    y_lo, y_hi, x_lo, x_hi;
  logic                    py_lo, py_hi, px_lo, px_hi;
  logic [gprkq_pkg::BTN_W-1:0]    btn_rise;
  logic [gprkq_pkg::NUM_PUSH-1:0] hit;

  // press thresholds, exact so they may leave the byte range
  assign thr_lo = $signed({2'b00, axis_mid}) - $signed({2'b00, axis_margin});
  assign thr_hi = {2'b00, axis_mid} + {2'b00, axis_margin};

  // axis classification for the new and the previous report
  assign y_lo  = $signed({2'b00, axis_y}) < thr_lo;
  assign y_hi  = {2'b00, axis_y} > thr_hi;
  assign x_lo  = $signed({2'b00, axis_x}) < thr_lo;
  assign x_hi  = {2'b00, axis_x} > thr_hi;
  assign py_lo = $signed({2'b00, last_y_r}) < thr_lo;
  assign py_hi = {2'b00, last_y_r} > thr_hi;
  assign px_lo = $signed({2'b00, last_x_r}) < thr_lo;
  assign px_hi = {2'b00, last_x_r} > thr_hi;

  assign btn_rise = buttons & ~last_btn_r;

  // press edges in queueing order
  assign hit = {
    btn_rise[gprkq_pkg::BTN_R],
    btn_rise[gprkq_pkg::BTN_L],
    btn_rise[gprkq_pkg::BTN_Y],
    btn_rise[gprkq_pkg::BTN_X],
    btn_rise[gprkq_pkg::BTN_SELECT],
    btn_rise[gprkq_pkg::BTN_START],
    btn_rise[gprkq_pkg::BTN_A] | btn_rise[gprkq_pkg::BTN_B],
    x_hi & ~px_hi,
    x_lo & ~px_lo,
    y_hi & ~py_hi,
    y_lo & ~py_lo
  };

  // rank of each edge among the edges ahead of it
  always_comb begin
    push_req.hit = hit;
    for (int f = 0; f < gprkq_pkg::NUM_PUSH; f++) begin
      push_req.rank[f] = gprkq_pkg::RANK_W'($countones(
        hit & gprkq_pkg::NUM_PUSH'((1 << f) - 1)));
    end
    push_req.total = gprkq_pkg::RANK_W'($countones(hit));
  end

  // previous report
  always_comb begin
    last_x_nxt   = last_x_r;
    last_y_nxt   = last_y_r;
    last_btn_nxt = last_btn_r;
    if (report_en) begin
      last_x_nxt   = axis_x;
      last_y_nxt   = axis_y;
      last_btn_nxt = buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r   <= gprkq_pkg::AXIS_MID_RST;
      last_y_r   <= gprkq_pkg::AXIS_MID_RST;
      last_btn_r <= gprkq_pkg::BUTTONS_RST;
    end else begin
      last_x_r   <= last_x_nxt;
      last_y_r   <= last_y_nxt;
      last_btn_r <= last_btn_nxt;
    end
  end

endmodule

// ===== hw/rtl/gprkq_cell.sv =====
// ---------------------------------------------------------------------------
// gamepad key queue cell
// one queue slot: shifts toward the head on a pop, catches its code on a push
// ---------------------------------------------------------------------------
module gprkq_cell #(
  parameter int CNT_W = 6,
  parameter int IDX   = 0
) (
  input  logic                 clk,
  input  logic                 pop,
  input  logic                 push,
  input  logic [CNT_W-1:0]     fill,
  input  gprkq_pkg::push_req_t push_req,
  input  gprkq_pkg::key_code_t code_in,
  output gprkq_pkg::key_code_t code_out
);

  localparam int REL_W = (CNT_W > gprkq_pkg::RANK_W) ? CNT_W : gprkq_pkg::RANK_W;

  gprkq_pkg::key_code_t code_r, code_nxt;
  gprkq_pkg::key_code_t catch_code;
  logic [REL_W-1:0]     rel;
  logic                 ahead;
  logic                 catch_hit;

  // place of this slot behind the current tail
  assign ahead = fill <= CNT_W'(IDX);
  assign rel   = REL_W'(IDX) - REL_W'(fill);

  // pick the pushed code whose rank lands here
  always_comb begin
    catch_hit  = 1'b0;
    catch_code = gprkq_pkg::KEY_NONE;
    for (int f = 0; f < gprkq_pkg::NUM_PUSH; f++) begin
      if (push_req.hit[f] && push_req.rank[f] == rel[gprkq_pkg::RANK_W-1:0]) begin
        catch_hit  = 1'b1;
        catch_code = gprkq_pkg::PUSH_CODE[f];
      end
    end
    catch_hit = catch_hit && ahead && (rel < REL_W'(gprkq_pkg::NUM_PUSH));
  end

  // slot update
  always_comb begin
    priority if (pop) begin
      code_nxt = code_in;
    end else if (push && catch_hit) begin
      code_nxt = catch_code;
    end else begin
      code_nxt = code_r;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign code_out = code_r;

endmodule

// ===== hw/rtl/gamepad_report_key_queue_unit.sv =====
// ---------------------------------------------------------------------------
// gamepad report key queue unit
// turns gamepad reports into queued key codes and pops them on request
// ---------------------------------------------------------------------------
// usage:
//   in channel: one beat per report (tuser kind report) or per read request
//   (tuser kind read). a report yields no result; its press edges are queued
//   in fixed order, and codes that do not fit a full queue are dropped.
//   out channel: one beat per read, key code and the count still waiting;
//   an empty queue answers with key none and a count of zero.
//   cfg port: rest level (index 0) and margin (index 1), written only idle.
//   a read result is valid in the cycle after its beat is accepted.
//   throughput: one beat per cycle unless stalled; the queue is a row of slot
//   cells that shift one place toward the head on a pop and catch up to eleven
//   codes at the tail on a report, so a read sees the report just before it.
//   stall: the result sits in the output register; while it is not taken,
//   in_tready is low. in_tready is high again in the cycle it is taken.
//   reset: synchronous, active low; registers return to centre 127, margin
//   64, centred previous axes, no buttons and an empty queue. no clearing
//   pass, the block accepts beats in the first cycle after reset.
// ---------------------------------------------------------------------------
`include "gamepad_report_key_queue_unit_macros.svh"

module gamepad_report_key_queue_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // axis_x [7:0], axis_y [15:8], buttons [23:16]
  input  logic        in_tuser,   // kind [0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // key_code [3:0], queued_left [9:4], zero [15:10]
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + gprkq_pkg::RANK_W;

  logic [gprkq_pkg::AXIS_W-1:0] center_r, center_nxt;
  logic [gprkq_pkg::AXIS_W-1:0] margin_r, margin_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  gprkq_pkg::key_code_t         out_code_r, out_code_nxt;
  logic [gprkq_pkg::LEFT_W-1:0] out_left_r, out_left_nxt;

  logic                 in_acc;
  logic                 do_report;
  logic                 do_read;
  logic                 do_pop;
  gprkq_pkg::kind_t     in_kind;
  gprkq_pkg::push_req_t push_req;
  logic [SUM_W-1:0]     fill_sum;
  logic [SUM_W-1:0]     left_w;
  logic                 empty_ans;

  gprkq_pkg::key_code_t cell_code [QUEUE_DEPTH];
  gprkq_pkg::key_code_t cell_next [QUEUE_DEPTH];

  // beat acceptance
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign in_kind   = gprkq_pkg::kind_t'(in_tuser);
  assign do_report = in_acc && (in_kind == gprkq_pkg::KIND_REPORT);
  assign do_read   = in_acc && (in_kind == gprkq_pkg::KIND_READ);
  assign do_pop    = do_read && (cnt_r != '0);

  // configuration registers
  always_comb begin
    center_nxt = center_r;
    margin_nxt = margin_r;
    if (cfg_we) begin
      unique case (gprkq_pkg::cfg_index_t'(cfg_index))
        gprkq_pkg::CFG_AXIS_MID:    center_nxt = cfg_wdata;
        gprkq_pkg::CFG_AXIS_MARGIN: margin_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // press edge detection
  gprkq_edge u_edge (
    .clk         (clk),
    .rst_n       (rst_n),
    .report_en   (do_report),
    .axis_x      (in_tdata[7:0]),
    .axis_y      (in_tdata[15:8]),
    .buttons     (in_tdata[23:16]),
    .axis_mid    (center_r),
    .axis_margin (margin_r),
    .push_req    (push_req)
  );

  // row of queue slots, head at slot zero
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign cell_next[i] = cell_code[i];
    end else begin : g_body
      assign cell_next[i] = cell_code[i+1];
    end

    gprkq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .pop      (do_pop),
      .push     (do_report),
      .fill     (cnt_r),
      .push_req (push_req),
      .code_in  (cell_next[i]),
      .code_out (cell_code[i])
    );
  end

  // fill count, capped at the depth so surplus pushes fall away
  assign fill_sum = SUM_W'(cnt_r) + SUM_W'(push_req.total);
  assign left_w   = SUM_W'(cnt_r) - SUM_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (do_report) begin
      cnt_nxt = (fill_sum > SUM_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                 : fill_sum[CNT_W-1:0];
    end else if (do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_left_nxt  = out_left_r;
    priority if (do_read) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = do_pop ? cell_code[0] : gprkq_pkg::KEY_NONE;
      out_left_nxt  = do_pop ? left_w[gprkq_pkg::LEFT_W-1:0] : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= gprkq_pkg::AXIS_MID_RST;
      margin_r    <= gprkq_pkg::AXIS_MARGIN_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      center_r    <= center_nxt;
      margin_r    <= margin_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_left_r <= out_left_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_left_r, out_code_r};

  // answer to a read of an empty queue
  assign empty_ans = out_valid_r && (out_code_r == gprkq_pkg::KEY_NONE) &&
                     (out_left_r == '0) && (cnt_r == '0);

  // checks
  `GPRKQ_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `GPRKQ_ASSERT_NEXT(a_report_silent, clk, rst_n, do_report, !out_valid_r)
  `GPRKQ_ASSERT_NEXT(a_empty_read, clk, rst_n, do_read && (cnt_r == '0), empty_ans)
  `GPRKQ_ASSERT_NEXT(a_pop_count, clk, rst_n, do_pop, cnt_r == $past(cnt_r) - CNT_W'(1))

endmodule
